>>> hdl/rspe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder package
// Shared widths, register indexes, sequencer states and GF(256) arithmetic.
// ----------------------------------------------------------------------------
package rspe_pkg;

    // Symbol and parity sizing
    localparam int SYM_W       = 8;
    localparam int MAX_CORRECT = 16;
    localparam int MAX_PARITY  = 2 * MAX_CORRECT;
    localparam int T_W         = 5;
    localparam int PAR_CNT_W   = $clog2(MAX_PARITY + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // Configuration reset values
    localparam logic [T_W-1:0]   RST_CORRECT_COUNT  = 5'd8;
    localparam logic [SYM_W-1:0] RST_FIRST_ROOT     = 8'd0;
    localparam logic [SYM_W-1:0] RST_MESSAGE_LENGTH = 8'd223;
    localparam logic [8:0]       RST_FIELD_POLY     = 9'd285;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORRECT_COUNT  = 2'd0,
        CFG_FIRST_ROOT     = 2'd1,
        CFG_MESSAGE_LENGTH = 2'd2,
        CFG_FIELD_POLY     = 2'd3
    } t_cfg_reg;

    // Generator build sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEEK,
        ST_BUILD,
        ST_READY
    } t_gen_state;

    // Control word from the sequencer to the generator cells
    typedef struct packed {
        logic             init;
        logic             step;
        logic [SYM_W-1:0] root;
    } t_gen_ctrl;

    // Multiply by alpha (the value 2) with reduction by the low field bits.
    function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] red);
        gf_xtime = {a[SYM_W-2:0], 1'b0} ^ (a[SYM_W-1] ? red : '0);
    endfunction

    // Carry-less shift-and-add multiply in GF(256).
    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                                input logic [SYM_W-1:0] b,
                                                input logic [SYM_W-1:0] red);
        logic [SYM_W-1:0] x;
        logic [SYM_W-1:0] p;
        x = a;
        p = '0;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) begin
                p = p ^ x;
            end
            x = gf_xtime(x, red);
        end
        gf_mul = p;
    endfunction

endpackage

>>> hdl/rspe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder channels
// Valid/ready channels for message words, parity words and register writes.
// ----------------------------------------------------------------------------

// Message symbol channel
interface rspe_sym_if;
    import rspe_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] data_symbol;

    modport source (output valid, output data_symbol, input ready);
    modport sink   (input valid, input data_symbol, output ready);
endinterface

// Parity symbol channel
interface rspe_par_if;
    import rspe_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] parity_symbol;
    logic             parity_last;

    modport source (output valid, output parity_symbol, output parity_last, input ready);
    modport sink   (input valid, input parity_symbol, input parity_last, output ready);
endinterface

// Register write channel
interface rspe_cfg_if;
    import rspe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/rspe_gen_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generator coefficient cell
// Holds one coefficient of g(x) and multiplies it by (x + root) each step.
// ----------------------------------------------------------------------------
module rspe_gen_cell (
    input  logic                      i_clk,
    input  rspe_pkg::t_gen_ctrl       i_ctrl,
    input  logic [rspe_pkg::SYM_W-1:0] i_init_val,
    input  logic [rspe_pkg::SYM_W-1:0] i_prev,
    input  logic [rspe_pkg::SYM_W-1:0] i_red,
    output logic [rspe_pkg::SYM_W-1:0] o_coef
);
    import rspe_pkg::*;

    logic [SYM_W-1:0] r_coef;

    // New coefficient is the lower neighbour plus root times this one.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_coef <= i_init_val;
        end else if (i_ctrl.step) begin
            r_coef <= i_prev ^ gf_mul(i_ctrl.root, r_coef, i_red);
        end
    end

    assign o_coef = r_coef;

endmodule

>>> hdl/rspe_par_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity register cell
// One stage of the LFSR division: takes the upper neighbour plus feedback
// times its generator coefficient.
// ----------------------------------------------------------------------------
module rspe_par_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_shift,
    input  logic                      i_flush,
    input  logic [rspe_pkg::SYM_W-1:0] i_fb,
    input  logic [rspe_pkg::SYM_W-1:0] i_coef,
    input  logic [rspe_pkg::SYM_W-1:0] i_next,
    input  logic [rspe_pkg::SYM_W-1:0] i_red,
    output logic [rspe_pkg::SYM_W-1:0] o_value,
    output logic [rspe_pkg::SYM_W-1:0] o_new
);
    import rspe_pkg::*;

    logic [SYM_W-1:0] r_value;

    // Value this stage takes when a word is accepted.
    assign o_new = i_next ^ gf_mul(i_fb, i_coef, i_red);

    // Cleared on reset or restart, and emptied as the codeword's parity is handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_value <= '0;
        end else if (i_shift) begin
            r_value <= i_flush ? '0 : o_new;
        end
    end

    assign o_value = r_value;

endmodule

>>> hdl/rspe_gen_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generator build sequencer
// Finds alpha^first_root, then steps the coefficient cells once per root.
// ----------------------------------------------------------------------------
module rspe_gen_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [rspe_pkg::SYM_W-1:0]     i_first_root,
    input  logic [rspe_pkg::PAR_CNT_W-1:0] i_n,
    input  logic [rspe_pkg::SYM_W-1:0]     i_red,
    output rspe_pkg::t_gen_ctrl           o_ctrl,
    output logic                          o_ready
);
    import rspe_pkg::*;

    t_gen_state       r_state;
    t_gen_state       n_state;
    logic [SYM_W-1:0] r_root;
    logic [SYM_W-1:0] n_root;
    logic [SYM_W-1:0] r_count;
    logic [SYM_W-1:0] n_count;
    logic [SYM_W-1:0] w_exp;
    logic [SYM_W-1:0] w_last_root;
    logic [SYM_W-1:0] w_wrap;

    // Exponents are taken modulo 255, so 255 folds onto zero.
    assign w_exp       = (i_first_root == 8'd255) ? '0 : i_first_root;
    assign w_last_root = {{(SYM_W - PAR_CNT_W){1'b0}}, i_n} - 8'd1;

    // Build step after which the root exponent would reach 255 and restarts at zero.
    assign w_wrap = 8'd254 - w_exp;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                n_state = (w_exp == '0) ? ST_BUILD : ST_SEEK;
            end
            ST_SEEK: begin
                if (r_count == 8'd1) begin
                    n_state = ST_BUILD;
                end
            end
            ST_BUILD: begin
                if (r_count == w_last_root) begin
                    n_state = ST_READY;
                end
            end
            ST_READY: begin
                n_state = ST_READY;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        if (i_restart) begin
            n_state = ST_LOAD;
        end
    end

    // Root and step counter
    always_comb begin
        n_root  = r_root;
        n_count = r_count;
        case (r_state)
            ST_LOAD: begin
                n_root  = 8'd1;
                n_count = w_exp;
            end
            ST_SEEK: begin
                n_root  = gf_xtime(r_root, i_red);
                n_count = r_count - 8'd1;
            end
            ST_BUILD: begin
                n_root  = (r_count == w_wrap) ? 8'd1 : gf_xtime(r_root, i_red);
                n_count = r_count + 8'd1;
            end
            default: begin
                n_root  = r_root;
                n_count = r_count;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl.init = 1'b0;
        o_ctrl.step = 1'b0;
        o_ctrl.root = r_root;
        o_ready     = 1'b0;
        case (r_state)
            ST_LOAD:  o_ctrl.init = 1'b1;
            ST_BUILD: o_ctrl.step = 1'b1;
            ST_READY: o_ready     = 1'b1;
            default:  o_ready     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root  <= n_root;
        r_count <= n_count;
    end

endmodule

>>> hdl/reed_solomon_parity_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder
// GF(256) systematic encoder built from a row of generator cells and a row
// of parity cells, with an output bank that drains the parity words.
// ----------------------------------------------------------------------------
// A message word is taken in every cycle: all 2t parity cells update together
// through their own GF multipliers. After reset and after every register write
// the generator is rebuilt by the build sequencer; no word is taken during
// that time, while register writes are always taken. When the last word of a
// message arrives the 2t parity words move to an output bank and leave one per
// cycle while the receiver is ready, index 0 first, with parity_last on the
// final one; the next message may enter at once. The last word of a message
// is held off while the bank still holds the previous parity, so the rate is
// one word per cycle whenever message_length is greater than 2t and parity
// words are taken as soon as they are offered.
module reed_solomon_parity_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rspe_sym_if.sink          i_data,
    rspe_par_if.source        o_parity,
    rspe_cfg_if.sink          i_cfg
);
    import rspe_pkg::*;

    // Configuration registers
    logic [T_W-1:0]   r_correct_count;
    logic [SYM_W-1:0] r_first_root;
    logic [SYM_W-1:0] r_message_length;
    logic [8:0]       r_field_poly;

    logic                 w_cfg_fire;
    logic                 w_in_fire;
    logic                 w_out_fire;
    logic [T_W-1:0]       w_t;
    logic [PAR_CNT_W-1:0] w_n;
    logic [SYM_W-1:0]     w_len;
    logic [SYM_W-1:0]     w_red;
    logic                 w_last_word;
    logic                 w_gen_ready;
    t_gen_ctrl            w_gen_ctrl;
    logic [SYM_W-1:0]     w_fb;

    logic [SYM_W-1:0] w_coef    [0:MAX_PARITY];
    logic [SYM_W-1:0] w_par     [0:MAX_PARITY-1];
    logic [SYM_W-1:0] w_par_new [0:MAX_PARITY-1];

    logic [SYM_W-1:0]     r_count;
    logic [PAR_CNT_W-1:0] r_out_cnt;
    logic [SYM_W-1:0]     r_bank [0:MAX_PARITY-1];

    // Handshakes
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign w_in_fire  = i_data.valid && i_data.ready;
    assign w_out_fire = o_parity.valid && o_parity.ready;
    assign i_cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_correct_count  <= RST_CORRECT_COUNT;
            r_first_root     <= RST_FIRST_ROOT;
            r_message_length <= RST_MESSAGE_LENGTH;
            r_field_poly     <= RST_FIELD_POLY;
        end else if (w_cfg_fire) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_CORRECT_COUNT:  r_correct_count  <= i_cfg.data[T_W-1:0];
                CFG_FIRST_ROOT:     r_first_root     <= i_cfg.data[SYM_W-1:0];
                CFG_MESSAGE_LENGTH: r_message_length <= i_cfg.data[SYM_W-1:0];
                CFG_FIELD_POLY:     r_field_poly     <= i_cfg.data;
                default:            r_field_poly     <= r_field_poly;
            endcase
        end
    end

    // Effective correction count, parity length and message length
    always_comb begin
        if (r_correct_count == '0) begin
            w_t = 5'd1;
        end else if (r_correct_count > T_W'(MAX_CORRECT)) begin
            w_t = T_W'(MAX_CORRECT);
        end else begin
            w_t = r_correct_count;
        end
    end

    assign w_n   = {w_t, 1'b0};
    assign w_len = (r_message_length == '0) ? 8'd1 : r_message_length;
    assign w_red = r_field_poly[SYM_W-1:0];

    // Generator build sequencer
    rspe_gen_seq u_gen_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (w_cfg_fire),
        .i_first_root (r_first_root),
        .i_n          (w_n),
        .i_red        (w_red),
        .o_ctrl       (w_gen_ctrl),
        .o_ready      (w_gen_ready)
    );

    // Row of generator coefficient cells, g[0] to g[2t max]
    for (genvar j = 0; j <= MAX_PARITY; j++) begin : g_gen
        if (j == 0) begin : g_first
            rspe_gen_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_gen_ctrl),
                .i_init_val (8'd1),
                .i_prev     (8'd0),
                .i_red      (w_red),
                .o_coef     (w_coef[j])
            );
        end else begin : g_rest
            rspe_gen_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_gen_ctrl),
                .i_init_val (8'd0),
                .i_prev     (w_coef[j-1]),
                .i_red      (w_red),
                .o_coef     (w_coef[j])
            );
        end
    end

    // Message word counter
    assign w_last_word = (r_count == w_len - 8'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_fire) begin
            r_count <= '0;
        end else if (w_in_fire) begin
            r_count <= w_last_word ? '0 : r_count + 8'd1;
        end
    end

    assign i_data.ready = w_gen_ready && (!w_last_word || (r_out_cnt == '0));
    assign w_fb         = w_par[0] ^ i_data.data_symbol;

    // Row of parity cells; the stage at 2t-1 sees zero from above.
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_par
        logic [SYM_W-1:0] w_next;
        if (j == MAX_PARITY - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = (PAR_CNT_W'(j + 1) < w_n) ? w_par[j+1] : '0;
        end

        rspe_par_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_cfg_fire),
            .i_shift (w_in_fire),
            .i_flush (w_last_word),
            .i_fb    (w_fb),
            .i_coef  (w_coef[j+1]),
            .i_next  (w_next),
            .i_red   (w_red),
            .o_value (w_par[j]),
            .o_new   (w_par_new[j])
        );
    end

    // Output bank occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= '0;
        end else if (w_in_fire && w_last_word) begin
            r_out_cnt <= w_n;
        end else if (w_out_fire) begin
            r_out_cnt <= r_out_cnt - PAR_CNT_W'(1);
        end
    end

    // Output bank: loaded with a finished codeword's parity, then shifted down
    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_bank
        always_ff @(posedge i_clk) begin
            if (w_in_fire && w_last_word) begin
                r_bank[j] <= w_par_new[j];
            end else if (w_out_fire) begin
                if (j == MAX_PARITY - 1) begin
                    r_bank[j] <= '0;
                end else begin
                    r_bank[j] <= r_bank[(j + 1) % MAX_PARITY];
                end
            end
        end
    end

    assign o_parity.valid         = (r_out_cnt != '0);
    assign o_parity.parity_symbol = r_bank[0];
    assign o_parity.parity_last   = (r_out_cnt == PAR_CNT_W'(1));

    // The word counter never reaches the message length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < w_len)
        else $error("word counter beyond message length");

    // Completing a message fills the bank with exactly 2t words.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_last_word) |=> (r_out_cnt == $past(w_n)))
        else $error("parity bank not loaded with full parity length");

    // The word marked last empties the bank.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_parity.parity_last) |=> (r_out_cnt == '0))
        else $error("parity bank not empty after last word");

endmodule
